/* rtl/vofm_pkg.sv */
// ============================================================================
// vofm_pkg: shared types, constants and functions
// Command format between front and back, configuration bundle, back-end
// state encoding, reflected CRC-16 byte update and Manchester encoders.
// ============================================================================
`default_nettype none

package vofm_pkg;

  // Frame header layout: preamble, four TDP copies, PHR, HCS, three MHR bytes.
  localparam int unsigned HDR_BITS  = 196;
  localparam int unsigned HDR_WORDS = 12;
  // First header word that carries HCS bits.
  localparam int unsigned HCS_WORD  = 9;

  localparam logic [5:0]  WORD_CHIPS    = 6'd32;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
  localparam logic [63:0] PREAMBLE      = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [8:0]  PSDU_OVERHEAD = 9'd5;

  // Steps of the header checksum sequencer.
  localparam logic [2:0] CRC_HCS_LAST = 3'd3;
  localparam logic [2:0] CRC_DONE     = 3'd7;

  // Input opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TDP_PATTERN   = 3'd0;
  localparam logic [2:0] CFG_PHY_CHAN      = 3'd1;
  localparam logic [2:0] CFG_PHR_MCS       = 3'd2;
  localparam logic [2:0] CFG_PHR_BURST     = 3'd3;
  localparam logic [2:0] CFG_FRAME_KIND    = 3'd4;
  localparam logic [2:0] CFG_FRAME_VERSION = 3'd5;

  // Configuration reset values.
  localparam logic [14:0] TDP_RESET     = 15'd6014;
  localparam logic [2:0]  CHANNEL_RESET = 3'd0;
  localparam logic [5:0]  MCS_RESET     = 6'd4;
  localparam logic        BURST_RESET   = 1'b0;
  localparam logic [2:0]  KIND_RESET    = 3'd1;
  localparam logic [1:0]  VERSION_RESET = 2'd0;

  typedef enum logic {
    CMD_START,
    CMD_BYTE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;   // payload length on start, payload byte otherwise
    logic [7:0] seq;    // sequence number on start
    logic       last;   // final payload byte of the frame
  } cmd_t;

  typedef struct packed {
    logic [14:0] tdp_pattern;
    logic [2:0]  phy_chan;
    logic [5:0]  phr_mcs;
    logic        phr_burst;
    logic [2:0]  frame_kind;
    logic [1:0]  frame_version;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_FCS_HI,
    BK_FCS_LO
  } bk_state_e;

  // One byte of the reflected CRC-16, LSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // Each bit becomes two chips, 1 -> 10 and 0 -> 01, MSB first.
  function automatic logic [15:0] manch8(logic [7:0] d);
    logic [15:0] r;
    for (int i = 0; i < 8; i++) begin
      r[2*i+1] = d[i];
      r[2*i]   = ~d[i];
    end
    return r;
  endfunction

  function automatic logic [31:0] manch16(logic [15:0] d);
    return {manch8(d[15:8]), manch8(d[7:0])};
  endfunction

endpackage

`default_nettype wire

/* rtl/vlc_ook_frame_manchester_tx.sv */
// ============================================================================
// vlc_ook_frame_manchester_tx: OOK frame builder with Manchester chip output
// Top level: configuration registers, front end, command queue, back end.
// ============================================================================
// Usage. Input items arrive on in_valid_i/in_ready_o. A start item (opcode 0)
// carries the payload length and sequence number; each byte item (opcode 1)
// carries one payload byte. A byte that arrives with no open frame is taken
// and dropped. Results leave on out_valid_o/out_ready_i as 32-chip words with
// a chip count and a last-word flag. Configuration registers are written over
// a separate cfg channel that is always ready; write them only while idle.
// Timing. The input is taken in a two-entry command queue, so a transfer is
// accepted every cycle while the queue has room. An accepted byte passes
// through the queue into the chip accumulator, and the back end takes one
// byte per cycle while it is idle and its output register is free, so
// payload streams at one item per cycle unless the receiver stalls; the last
// byte of a frame is followed by the words that carry the FCS. A start item
// holds the back end while it loads the header and sends each of the twelve
// header words, and then the checksum words when the payload is empty. The
// header checksum runs in parallel and is ready before the word that needs it.
// Reset clears all control state and loads the configuration defaults; no
// frame is open after reset. When the receiver stalls, the output register
// holds its word, the back end stops, and the queue fills and then deasserts
// in_ready_o; nothing is dropped.
// ============================================================================
`default_nettype none

module vlc_ook_frame_manchester_tx (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write channel.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i,
  // Input item channel.
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic [7:0]  payload_length_i,
  input  wire logic [7:0]  seq_number_i,
  // Chip word channel.
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      chip_word_o,
  output logic [5:0]       chip_count_o,
  output logic             last_word_o
);
  import vofm_pkg::*;

  cfg_t cfg_q;
  logic fifo_full, fifo_empty, push, pop;
  cmd_t push_cmd, head_cmd;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tdp_pattern   <= TDP_RESET;
      cfg_q.phy_chan      <= CHANNEL_RESET;
      cfg_q.phr_mcs       <= MCS_RESET;
      cfg_q.phr_burst     <= BURST_RESET;
      cfg_q.frame_kind    <= KIND_RESET;
      cfg_q.frame_version <= VERSION_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TDP_PATTERN:   cfg_q.tdp_pattern   <= cfg_data_i;
        CFG_PHY_CHAN:      cfg_q.phy_chan      <= cfg_data_i[2:0];
        CFG_PHR_MCS:       cfg_q.phr_mcs       <= cfg_data_i[5:0];
        CFG_PHR_BURST:     cfg_q.phr_burst     <= cfg_data_i[0];
        CFG_FRAME_KIND:    cfg_q.frame_kind    <= cfg_data_i[2:0];
        CFG_FRAME_VERSION: cfg_q.frame_version <= cfg_data_i[1:0];
        default: ;  // Writes to unused indexes are ignored.
      endcase
    end
  end

  // The front end classifies items and tracks the open frame.
  vofm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .payload_byte_i   (payload_byte_i),
    .payload_length_i (payload_length_i),
    .seq_number_i     (seq_number_i),
    .fifo_full_i      (fifo_full),
    .push_o           (push),
    .push_cmd_o       (push_cmd)
  );

  // The queue lets the front keep accepting while the back end is busy.
  vofm_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .empty_o    (fifo_empty),
    .head_o     (head_cmd)
  );

  // The back end packs chips into words held in its output register.
  vofm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_valid_i  (~fifo_empty),
    .cmd_i        (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .chip_word_o  (chip_word_o),
    .chip_count_o (chip_count_o),
    .last_word_o  (last_word_o)
  );

endmodule

`default_nettype wire

/* rtl/vofm_front.sv */
// ============================================================================
// vofm_front: input acceptance and classification
// Tracks the open frame and turns input items into start and byte commands.
// Bytes that arrive with no open frame are taken and dropped.
// ============================================================================
`default_nettype none

module vofm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          opcode_i,
  input  wire logic [7:0]    payload_byte_i,
  input  wire logic [7:0]    payload_length_i,
  input  wire logic [7:0]    seq_number_i,
  input  wire logic          fifo_full_i,
  output logic               push_o,
  output vofm_pkg::cmd_t     push_cmd_o
);
  import vofm_pkg::*;

  logic       open_q, open_d;
  logic [7:0] left_q, left_d;
  logic       accept;

  assign in_ready_o = ~fifo_full_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    open_d     = open_q;
    left_d     = left_q;
    push_o     = 1'b0;
    push_cmd_o = '{kind: CMD_START, data: payload_length_i, seq: seq_number_i,
                   last: 1'b0};
    if (accept) begin
      if (opcode_i == OP_START) begin
        // A new start abandons whatever frame was open.
        push_o = 1'b1;
        open_d = (payload_length_i != 8'd0);
        left_d = payload_length_i;
      end else if (open_q) begin
        push_o          = 1'b1;
        push_cmd_o.kind = CMD_BYTE;
        push_cmd_o.data = payload_byte_i;
        push_cmd_o.last = (left_q == 8'd1);
        left_d          = left_q - 8'd1;
        open_d          = (left_q != 8'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= 8'd0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/vofm_cmd_fifo.sv */
// ============================================================================
// vofm_cmd_fifo: two-entry command queue
// Decouples the classifying front end from the chip word generator.
// ============================================================================
`default_nettype none

module vofm_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire vofm_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output vofm_pkg::cmd_t     head_o
);
  import vofm_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("command queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("command queue underflow");

endmodule

`default_nettype wire

/* rtl/vofm_back.sv */
// ============================================================================
// vofm_back: chip word generator
// Builds the frame header, runs the checksums, Manchester-encodes and packs
// chips into 32-chip words held in an output register.
// ============================================================================
`default_nettype none

module vofm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire vofm_pkg::cfg_t cfg_i,
  input  wire logic           cmd_valid_i,
  input  wire vofm_pkg::cmd_t cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         chip_word_o,
  output logic [5:0]          chip_count_o,
  output logic                last_word_o
);
  import vofm_pkg::*;

  bk_state_e            state_q, state_d;
  logic [HDR_BITS-1:0]  hdr_q, hdr_d;
  logic [3:0]           widx_q, widx_d;
  logic                 zero_len_q, zero_len_d;
  logic [2:0]           step_q, step_d;
  logic [15:0]          crc_q, crc_d;
  logic [31:0]          acc_q, acc_d;
  logic [5:0]           fill_q, fill_d;
  logic                 valid_q, valid_d;
  logic [31:0]          word_q, word_d;
  logic [5:0]           count_q, count_d;
  logic                 last_q, last_d;

  logic                 out_free, pop, hdr_go, seq_run;
  logic [7:0]           crc_in, hdr_top;
  logic [15:0]          crc_next, nib_chips, byte_chips;
  logic [31:0]          phr;
  logic [8:0]           psdu;
  logic [47:0]          comb48;
  logic [63:0]          comb64;
  logic [6:0]           sum_fill;

  assign out_free = ~valid_q | out_ready_i;
  assign seq_run  = (step_q != CRC_DONE);
  assign pop      = (state_q == BK_IDLE) & cmd_valid_i & out_free;
  assign hdr_go   = (state_q == BK_HDR) & out_free &
                    ((widx_q < 4'(HCS_WORD)) | ~seq_run);
  assign pop_o    = pop;

  assign hdr_top    = 8'(HDR_BITS - 1) - {widx_q, 4'b0000};
  assign nib_chips  = manch8({hdr_q[3:0], 4'b0000});
  assign byte_chips = manch8(cmd_i.data);
  assign psdu       = {1'b0, cmd_i.data} + PSDU_OVERHEAD;
  assign phr        = {cfg_i.phr_burst, cfg_i.phy_chan, cfg_i.phr_mcs,
                       7'd0, psdu, 6'd0};
  assign comb48     = {acc_q, 16'd0} | ({byte_chips, 32'd0} >> fill_q);
  assign comb64     = {acc_q, 32'd0} | ({manch16(crc_q), 32'd0} >> fill_q);
  assign sum_fill   = {1'b0, fill_q} + 7'd16;

  // Checksum byte source: the command byte in idle, else the header bytes.
  always_comb begin
    if (state_q == BK_IDLE) begin
      crc_in = cmd_i.data;
    end else begin
      case (step_q)
        3'd0:    crc_in = hdr_q[71:64];
        3'd1:    crc_in = hdr_q[63:56];
        3'd2:    crc_in = hdr_q[55:48];
        3'd3:    crc_in = hdr_q[47:40];
        3'd4:    crc_in = hdr_q[23:16];
        3'd5:    crc_in = hdr_q[15:8];
        3'd6:    crc_in = hdr_q[7:0];
        default: crc_in = 8'd0;
      endcase
    end
  end

  assign crc_next = crc_byte(crc_q, crc_in);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop && cmd_i.kind == CMD_START) begin
          state_d = BK_HDR;
        end else if (pop && cmd_i.last) begin
          state_d = BK_FCS_HI;
        end
      end
      BK_HDR: begin
        if (hdr_go && widx_q == 4'(HDR_WORDS - 1)) begin
          state_d = zero_len_q ? BK_FCS_HI : BK_IDLE;
        end
      end
      BK_FCS_HI: begin
        if (out_free) begin
          state_d = (fill_q == 6'd0) ? BK_IDLE : BK_FCS_LO;
        end
      end
      BK_FCS_LO: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    hdr_d      = hdr_q;
    widx_d     = widx_q;
    zero_len_d = zero_len_q;
    step_d     = step_q;
    crc_d      = crc_q;
    acc_d      = acc_q;
    fill_d     = fill_q;
    valid_d    = valid_q & ~out_ready_i;
    word_d     = word_q;
    count_d    = count_q;
    last_d     = last_q;

    // Header checksum sequencer: HCS over the PHR, then the MHR into the FCS.
    if (seq_run) begin
      step_d = step_q + 3'd1;
      if (step_q == CRC_HCS_LAST) begin
        hdr_d[39:24] = crc_next;
        crc_d        = CRC_INIT;
      end else begin
        crc_d = crc_next;
      end
    end

    case (state_q)
      BK_IDLE: begin
        if (pop) begin
          if (cmd_i.kind == CMD_START) begin
            hdr_d = {PREAMBLE, cfg_i.tdp_pattern, ~cfg_i.tdp_pattern,
                     cfg_i.tdp_pattern, ~cfg_i.tdp_pattern, phr, CRC_INIT,
                     7'd0, cfg_i.frame_kind[2],
                     cfg_i.frame_kind[1:0], 4'd0, cfg_i.frame_version,
                     cmd_i.seq};
            widx_d     = 4'd0;
            step_d     = 3'd0;
            crc_d      = CRC_INIT;
            acc_d      = 32'd0;
            fill_d     = 6'd0;
            zero_len_d = (cmd_i.data == 8'd0);
          end else begin
            crc_d = crc_next;
            if (sum_fill >= 7'd32) begin
              valid_d = 1'b1;
              word_d  = comb48[47:16];
              count_d = WORD_CHIPS;
              last_d  = 1'b0;
              acc_d   = {comb48[15:0], 16'd0};
              fill_d  = 6'(sum_fill - 7'd32);
            end else begin
              acc_d  = comb48[47:16];
              fill_d = sum_fill[5:0];
            end
          end
        end
      end
      BK_HDR: begin
        if (hdr_go) begin
          valid_d = 1'b1;
          word_d  = manch16(hdr_q[hdr_top -: 16]);
          count_d = WORD_CHIPS;
          last_d  = 1'b0;
          widx_d  = widx_q + 4'd1;
          if (widx_q == 4'(HDR_WORDS - 1)) begin
            // The last four header bits stay pending as eight chips.
            acc_d  = {nib_chips[15:8], 24'd0};
            fill_d = 6'd8;
          end
        end
      end
      BK_FCS_HI: begin
        if (out_free) begin
          valid_d = 1'b1;
          word_d  = comb64[63:32];
          count_d = WORD_CHIPS;
          last_d  = (fill_q == 6'd0);
          acc_d   = comb64[31:0];
        end
      end
      BK_FCS_LO: begin
        if (out_free) begin
          valid_d = 1'b1;
          word_d  = acc_q;
          count_d = fill_q;
          last_d  = 1'b1;
          acc_d   = 32'd0;
          fill_d  = 6'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      widx_q     <= 4'd0;
      zero_len_q <= 1'b0;
      step_q     <= CRC_DONE;
      crc_q      <= CRC_INIT;
      acc_q      <= 32'd0;
      fill_q     <= 6'd0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      widx_q     <= widx_d;
      zero_len_q <= zero_len_d;
      step_q     <= step_d;
      crc_q      <= crc_d;
      acc_q      <= acc_d;
      fill_q     <= fill_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q   <= hdr_d;
    word_q  <= word_d;
    count_q <= count_d;
    last_q  <= last_d;
  end

  assign out_valid_o  = valid_q;
  assign chip_word_o  = word_q;
  assign chip_count_o = count_q;
  assign last_word_o  = last_q;

  a_idle_crc_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_IDLE) |-> (step_q == CRC_DONE))
    else $error("idle with header checksum still running");

  a_fill_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < WORD_CHIPS) else $error("chip fill out of range");

  a_tail_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_FCS_LO) |-> (fill_q != 6'd0))
    else $error("empty tail word");

  a_hdr_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_HDR) |-> (widx_q < 4'(HDR_WORDS)))
    else $error("header word index out of range");

endmodule

`default_nettype wire
